// File: design/rot_pkg.sv
// ----------------------------------------------------------------------------
// rot_pkg
// shared constants, codes and control types for the retry outbox table
// ----------------------------------------------------------------------------
package rot_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
  localparam logic [1:0] MODE_TAKE     = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;
  localparam logic [1:0] MODE_REMOVE   = 2'd3;

  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_INFLIGHT = 2'd1;
  localparam logic [1:0] ST_SENT     = 2'd2;
  localparam logic [1:0] ST_FAILED   = 2'd3;

  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_INVALID   = 2'd1;
  localparam logic [1:0] RES_CAPACITY  = 2'd2;
  localparam logic [1:0] RES_NOT_FOUND = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// File: design/retry_outbox_table.sv
// an accepted request walks the table one entry per cycle; enqueue and a complete
// with id zero stop on the first step, take-next, complete and remove-sent walk at
// most to the end of the table, and the result appears the cycle after the last step;
// one request at a time: a new request is stalled until the result is taken, and
// the walk reads entries through the single read port of the entry register file
// reset: table empty, next id one, capacity 16, attempt counts zero; no clearing pass
// ----------------------------------------------------------------------------
// retry_outbox_table
// outgoing message table with delivery tracking, apb capacity register
// ----------------------------------------------------------------------------
module retry_outbox_table
  import rot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [31:0]       message_tag,
  input  logic [63:0]       target_id,
  input  logic [7:0]        completion_status,
  input  logic              retryable,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        result_code,
  output logic [63:0]       record_id_out,
  output logic [31:0]       message_tag_out,
  output logic [31:0]       attempts_out,
  output logic [7:0]        last_status_out,
  output logic [CNT_W-1:0]  removed_count,
  output logic [CNT_W-1:0]  record_count,
  output logic [CNT_W-1:0]  sent_count,
  output logic [CNT_W-1:0]  failed_count,
  output logic [CNT_W-1:0]  pending_count
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [4:0] capacity_limit;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_CAPACITY) begin
      capacity_limit <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (reg_sel)
      REG_CAPACITY: prdata = {27'd0, capacity_limit};
      default:      prdata = 32'd0;
    endcase
  end

  rot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  rot_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .capacity_limit    (capacity_limit),
    .mode              (mode),
    .message_tag       (message_tag),
    .target_id         (target_id),
    .completion_status (completion_status),
    .retryable         (retryable),
    .result_code       (result_code),
    .record_id_out     (record_id_out),
    .message_tag_out   (message_tag_out),
    .attempts_out      (attempts_out),
    .last_status_out   (last_status_out),
    .removed_count     (removed_count),
    .record_count      (record_count),
    .sent_count        (sent_count),
    .failed_count      (failed_count),
    .pending_count     (pending_count)
  );

endmodule

// File: design/rot_ctrl.sv
// ----------------------------------------------------------------------------
// rot_ctrl
// request sequencer: accept, walk the table, hold the result until taken
// ----------------------------------------------------------------------------
module rot_ctrl
  import rot_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_BUSY;
      end
      S_BUSY: begin
        if (status.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.step  = (state == S_BUSY);

`ifndef SYNTHESIS
  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_BUSY))
    else $error("accepted request did not start the walk");

  a_last_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUSY && status.last) |=> (state == S_DONE))
    else $error("finished walk did not present a result");
`endif

endmodule

// File: design/rot_dp.sv
// ----------------------------------------------------------------------------
// rot_dp
// entry table, walk pointers, state counters and result registers
// ----------------------------------------------------------------------------
module rot_dp
  import rot_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [4:0]        capacity_limit,
  input  logic [1:0]        mode,
  input  logic [31:0]       message_tag,
  input  logic [63:0]       target_id,
  input  logic [7:0]        completion_status,
  input  logic              retryable,
  output logic [1:0]        result_code,
  output logic [63:0]       record_id_out,
  output logic [31:0]       message_tag_out,
  output logic [31:0]       attempts_out,
  output logic [7:0]        last_status_out,
  output logic [CNT_W-1:0]  removed_count,
  output logic [CNT_W-1:0]  record_count,
  output logic [CNT_W-1:0]  sent_count,
  output logic [CNT_W-1:0]  failed_count,
  output logic [CNT_W-1:0]  pending_count
);

  logic [63:0] ent_id    [DEPTH];
  logic [31:0] ent_tag   [DEPTH];
  logic [1:0]  ent_state [DEPTH];
  logic [31:0] ent_att   [DEPTH];
  logic [7:0]  ent_ls    [DEPTH];

  logic [1:0]       op_mode;
  logic [31:0]      op_tag;
  logic [63:0]      op_rid;
  logic [7:0]       op_status;
  logic             op_retry;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] wr_ptr;
  logic [CNT_W-1:0] removed;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] sent_cnt;
  logic [CNT_W-1:0] failed_cnt;
  logic [CNT_W-1:0] pend_cnt;
  logic [63:0]      next_id;

  logic [IDX_W-1:0] rd_idx;
  logic [63:0]      cur_id;
  logic [31:0]      cur_tag;
  logic [1:0]       cur_state;
  logic [31:0]      cur_att;
  logic [7:0]       cur_ls;
  logic             at_end;
  logic             rid_zero;
  logic             id_hit;
  logic [CNT_W-1:0] usable;
  logic             full;
  logic [1:0]       new_state;
  logic             old_sent;
  logic             old_failed;
  logic             new_sent;
  logic             new_failed;

  logic do_enq;
  logic do_take;
  logic do_complete;
  logic do_move;
  logic do_clear;

  assign rd_idx    = idx[IDX_W-1:0];
  assign cur_id    = ent_id[rd_idx];
  assign cur_tag   = ent_tag[rd_idx];
  assign cur_state = ent_state[rd_idx];
  assign cur_att   = ent_att[rd_idx];
  assign cur_ls    = ent_ls[rd_idx];
  assign at_end    = (idx == count);
  assign rid_zero  = (op_rid == 64'd0);
  assign id_hit    = (cur_id == op_rid);
  assign usable    = (capacity_limit > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_limit;
  assign full      = (count >= usable);

  assign new_state  = (op_status == 8'd0) ? ST_SENT : (op_retry ? ST_PENDING : ST_FAILED);
  assign old_sent   = (cur_state == ST_SENT);
  assign old_failed = (cur_state == ST_FAILED);
  assign new_sent   = (new_state == ST_SENT);
  assign new_failed = (new_state == ST_FAILED);

  always_comb begin
    status.last = 1'b0;
    case (op_mode)
      MODE_ENQUEUE:  status.last = 1'b1;
      MODE_TAKE:     status.last = at_end || (cur_state == ST_PENDING);
      MODE_COMPLETE: status.last = rid_zero || at_end || id_hit;
      default:       status.last = at_end;
    endcase
  end

  assign do_enq      = cmd.step && (op_mode == MODE_ENQUEUE) && !full;
  assign do_take     = cmd.step && (op_mode == MODE_TAKE) && !at_end
                       && (cur_state == ST_PENDING);
  assign do_complete = cmd.step && (op_mode == MODE_COMPLETE) && !rid_zero
                       && !at_end && id_hit;
  assign do_move     = cmd.step && (op_mode == MODE_REMOVE) && !at_end
                       && !old_sent;
  assign do_clear    = do_move && (wr_ptr != idx);

  // entry payload, undefined until written
  always_ff @(posedge clk) begin
    if (do_enq) begin
      ent_id[count[IDX_W-1:0]]    <= next_id;
      ent_tag[count[IDX_W-1:0]]   <= op_tag;
      ent_state[count[IDX_W-1:0]] <= ST_PENDING;
      ent_ls[count[IDX_W-1:0]]    <= 8'd0;
    end
    if (do_take) begin
      ent_state[rd_idx] <= ST_INFLIGHT;
    end
    if (do_complete) begin
      ent_state[rd_idx] <= new_state;
      ent_ls[rd_idx]    <= op_status;
    end
    if (do_clear) begin
      ent_id[wr_ptr[IDX_W-1:0]]    <= cur_id;
      ent_tag[wr_ptr[IDX_W-1:0]]   <= cur_tag;
      ent_state[wr_ptr[IDX_W-1:0]] <= cur_state;
      ent_ls[wr_ptr[IDX_W-1:0]]    <= cur_ls;
    end
  end

  // attempt counts start from zero and survive slot reuse
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        ent_att[k] <= 32'd0;
      end
    end else begin
      if (do_take) begin
        ent_att[rd_idx] <= cur_att + 32'd1;
      end
      if (do_clear) begin
        ent_att[wr_ptr[IDX_W-1:0]] <= cur_att;
        ent_att[rd_idx]            <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sent_cnt   <= '0;
      failed_cnt <= '0;
      pend_cnt   <= '0;
      next_id    <= 64'd1;
      idx        <= '0;
      wr_ptr     <= '0;
      removed    <= '0;
    end else if (cmd.load) begin
      idx     <= '0;
      wr_ptr  <= '0;
      removed <= '0;
    end else if (cmd.step) begin
      if (do_enq) begin
        count    <= count + CNT_W'(1);
        pend_cnt <= pend_cnt + CNT_W'(1);
        next_id  <= next_id + 64'd1;
      end
      if (do_complete) begin
        sent_cnt   <= sent_cnt - CNT_W'(old_sent) + CNT_W'(new_sent);
        failed_cnt <= failed_cnt - CNT_W'(old_failed) + CNT_W'(new_failed);
        pend_cnt   <= pend_cnt + CNT_W'(old_sent || old_failed)
                      - CNT_W'(new_sent || new_failed);
      end
      if (op_mode == MODE_REMOVE && at_end) begin
        count    <= wr_ptr;
        sent_cnt <= '0;
      end
      if (!status.last) begin
        idx <= idx + CNT_W'(1);
      end
      if (op_mode == MODE_REMOVE && !at_end) begin
        if (old_sent) begin
          removed <= removed + CNT_W'(1);
        end else begin
          wr_ptr <= wr_ptr + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode         <= mode;
      op_tag          <= message_tag;
      op_rid          <= target_id;
      op_status       <= completion_status;
      op_retry        <= retryable;
      result_code     <= RES_OK;
      record_id_out   <= 64'd0;
      message_tag_out <= 32'd0;
      attempts_out    <= 32'd0;
      last_status_out <= 8'd0;
      removed_count   <= '0;
    end else if (cmd.step && status.last) begin
      case (op_mode)
        MODE_ENQUEUE: begin
          if (full) begin
            result_code <= RES_CAPACITY;
          end else begin
            record_id_out <= next_id;
          end
        end
        MODE_TAKE: begin
          if (at_end) begin
            result_code <= RES_NOT_FOUND;
          end else begin
            record_id_out   <= cur_id;
            message_tag_out <= cur_tag;
            attempts_out    <= cur_att + 32'd1;
            last_status_out <= cur_ls;
          end
        end
        MODE_COMPLETE: begin
          if (rid_zero) begin
            result_code <= RES_INVALID;
          end else if (at_end) begin
            result_code <= RES_NOT_FOUND;
          end
        end
        default: begin
          removed_count <= removed;
        end
      endcase
    end
  end

  assign record_count  = count;
  assign sent_count    = sent_cnt;
  assign failed_count  = failed_cnt;
  assign pending_count = pend_cnt;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_class_sum: assert property (@(posedge clk) disable iff (rst)
    ({2'b00, sent_cnt} + {2'b00, failed_cnt} + {2'b00, pend_cnt}) == {2'b00, count})
    else $error("state counters disagree with entry count");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= idx)
    else $error("compaction write pointer ahead of read pointer");
`endif

endmodule
